[design/plcs_pkg.sv]
package plcs_pkg;

  // Default grey-level width; the top level can override it from 8 to 16.
  localparam int PIXEL_BITS_DEF = 8;

  // Configuration bus: four 32-bit registers at byte addresses 0, 4, 8 and 12.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;
  localparam int REG_IDX_BITS = 2;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_IN_KNEE_LOW   = 2'd0,
    REG_OUT_KNEE_LOW  = 2'd1,
    REG_IN_KNEE_HIGH  = 2'd2,
    REG_OUT_KNEE_HIGH = 2'd3
  } reg_idx_t;

endpackage

[design/plcs_setup.sv]
module plcs_setup #(
  parameter int PIXEL_BITS = plcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic [PIXEL_BITS-1:0] r1,
  input  logic [PIXEL_BITS-1:0] s1,
  input  logic [PIXEL_BITS-1:0] r2,
  input  logic [PIXEL_BITS-1:0] s2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] mul_a0,
  output logic [PIXEL_BITS-1:0] mul_b0,
  output logic [PIXEL_BITS-1:0] mul_a1,
  output logic [PIXEL_BITS-1:0] mul_b1,
  output logic [PIXEL_BITS-1:0] width
);
  import plcs_pkg::*;

  localparam logic [PIXEL_BITS-1:0] MAXV = '1;
  localparam logic [PIXEL_BITS-1:0] ONE  = PIXEL_BITS'(1);
  localparam logic [PIXEL_BITS-1:0] ZERO = '0;

  logic [PIXEL_BITS-1:0] a0_next, b0_next, a1_next, b1_next, width_next;

  // Each segment becomes a0*b0 + a1*b1 over a width. A segment of zero width
  // is turned into its end value times one, divided by one.
  always_comb begin
    if (pixel <= r1) begin
      a1_next = ZERO;
      b1_next = ZERO;
      a0_next = s1;
      if (r1 == ZERO) begin
        b0_next    = ONE;
        width_next = ONE;
      end else begin
        b0_next    = pixel;
        width_next = r1;
      end
    end else if (pixel <= r2) begin
      if (r2 == r1) begin
        a0_next    = s2;
        b0_next    = ONE;
        a1_next    = ZERO;
        b1_next    = ZERO;
        width_next = ONE;
      end else begin
        a0_next    = s1;
        b0_next    = r2 - pixel;
        a1_next    = s2;
        b1_next    = pixel - r1;
        width_next = r2 - r1;
      end
    end else begin
      if (r2 == MAXV) begin
        a0_next    = MAXV;
        b0_next    = ONE;
        a1_next    = ZERO;
        b1_next    = ZERO;
        width_next = ONE;
      end else begin
        a0_next    = s2;
        b0_next    = MAXV - pixel;
        a1_next    = MAXV;
        b1_next    = pixel - r2;
        width_next = MAXV - r2;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_a0 <= a0_next;
      mul_b0 <= b0_next;
      mul_a1 <= a1_next;
      mul_b1 <= b1_next;
      width  <= width_next;
    end
  end

endmodule

[design/plcs_mul.sv]
module plcs_mul #(
  parameter int PIXEL_BITS = plcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_BITS-1:0]   a0,
  input  logic [PIXEL_BITS-1:0]   b0,
  input  logic [PIXEL_BITS-1:0]   a1,
  input  logic [PIXEL_BITS-1:0]   b1,
  input  logic [PIXEL_BITS-1:0]   width_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*PIXEL_BITS-1:0] num,
  output logic [PIXEL_BITS-1:0]   width
);
  import plcs_pkg::*;

  logic [2*PIXEL_BITS-1:0] prod0, prod1, num_next;

  assign prod0 = {{PIXEL_BITS{1'b0}}, a0} * {{PIXEL_BITS{1'b0}}, b0};
  assign prod1 = {{PIXEL_BITS{1'b0}}, a1} * {{PIXEL_BITS{1'b0}}, b1};
  // The sum is at most MAXV times the width, so it never carries out.
  assign num_next = prod0 + prod1;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      num   <= num_next;
      width <= width_in;
    end
  end

endmodule

[design/plcs_div.sv]
module plcs_div #(
  parameter int PIXEL_BITS = plcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2*PIXEL_BITS-1:0] num,
  input  logic [PIXEL_BITS-1:0]   width,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIXEL_BITS-1:0]   quotient
);
  import plcs_pkg::*;

  localparam int STAGES = PIXEL_BITS;

  // One quotient bit per stage, restoring division. The numerator is below
  // width * 2^PIXEL_BITS, so its upper half already sits below the width.
  logic                  vld [STAGES];
  logic                  rdy [STAGES];
  logic [PIXEL_BITS-1:0] lo  [STAGES];
  logic [PIXEL_BITS-1:0] rem [STAGES-1];
  logic [PIXEL_BITS-1:0] wd  [STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [PIXEL_BITS-1:0] src_rem, src_lo, src_w;
    logic                  src_v, dn_rdy, take;
    logic [PIXEL_BITS:0]   trial;

    if (k == 0) begin : g_first
      assign src_rem = num[2*PIXEL_BITS-1:PIXEL_BITS];
      assign src_lo  = num[PIXEL_BITS-1:0];
      assign src_w   = width;
      assign src_v   = in_valid;
    end else begin : g_next
      assign src_rem = rem[k-1];
      assign src_lo  = lo[k-1];
      assign src_w   = wd[k-1];
      assign src_v   = vld[k-1];
    end

    if (k == STAGES-1) begin : g_last
      assign dn_rdy = out_ready;
    end else begin : g_mid
      assign dn_rdy = rdy[k+1];
    end

    assign trial  = {src_rem, src_lo[PIXEL_BITS-1]};
    assign take   = trial >= {1'b0, src_w};
    assign rdy[k] = !vld[k] || dn_rdy;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        lo[k] <= {src_lo[PIXEL_BITS-2:0], take};
      end
    end

    if (k < STAGES-1) begin : g_keep
      logic [PIXEL_BITS:0] diff;

      assign diff = trial - {1'b0, src_w};

      always_ff @(posedge clk) begin
        if (rdy[k] && src_v) begin
          rem[k] <= take ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
          wd[k]  <= src_w;
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[STAGES-1];
  assign quotient  = lo[STAGES-1];

endmodule

[design/piecewise_linear_contrast_stretch_unit.sv]
// Piecewise linear contrast stretch: maps each grey pixel through the line
// (0,0) - (r1,s1) - (r2,s2) - (MAXV,MAXV), truncating each segment value.
//
// Pixels enter on in_valid/in_ready/pixel_in and leave on
// out_valid/out_ready/pixel_out, one result per input transfer, in order.
// The knee points are set through the APB port: in_knee_low at 0x0,
// out_knee_low at 0x4, in_knee_high at 0x8, out_knee_high at 0xC. They are
// to be changed only while no pixel is in flight.
//
// The pipeline has one stage that selects the segment, one that forms the
// weighted sum with two multipliers, and a divider with one stage per
// quotient bit that finishes the result. A new pixel can be taken every
// cycle while the output is not stalled.
//
// Reset (rst, synchronous) empties the pipeline and sets the knees to
// (0,0) and (MAXV,MAXV), the identity map. When out_ready is low the stages
// fill up behind the output and in_ready drops only once all are full; no
// transfer is lost or repeated.
module piecewise_linear_contrast_stretch_unit #(
  parameter int PIXEL_BITS = plcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [plcs_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [plcs_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [plcs_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [PIXEL_BITS-1:0]              pixel_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [PIXEL_BITS-1:0]              pixel_out
);
  import plcs_pkg::*;

  localparam logic [PIXEL_BITS-1:0] MAXV = '1;

  logic [PIXEL_BITS-1:0] in_knee_low, out_knee_low, in_knee_high, out_knee_high;
  logic [PIXEL_BITS-1:0] read_val;
  reg_idx_t              reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_knee_low   <= '0;
      out_knee_low  <= '0;
      in_knee_high  <= MAXV;
      out_knee_high <= MAXV;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IN_KNEE_LOW:   in_knee_low   <= pwdata[PIXEL_BITS-1:0];
        REG_OUT_KNEE_LOW:  out_knee_low  <= pwdata[PIXEL_BITS-1:0];
        REG_IN_KNEE_HIGH:  in_knee_high  <= pwdata[PIXEL_BITS-1:0];
        REG_OUT_KNEE_HIGH: out_knee_high <= pwdata[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IN_KNEE_LOW:   read_val = in_knee_low;
      REG_OUT_KNEE_LOW:  read_val = out_knee_low;
      REG_IN_KNEE_HIGH:  read_val = in_knee_high;
      REG_OUT_KNEE_HIGH: read_val = out_knee_high;
      default:           read_val = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_BITS-PIXEL_BITS){1'b0}}, read_val};

  logic                    setup_valid, setup_ready;
  logic [PIXEL_BITS-1:0]   a0, b0, a1, b1, setup_width;
  logic                    mul_valid, mul_ready;
  logic [2*PIXEL_BITS-1:0] mul_num;
  logic [PIXEL_BITS-1:0]   mul_width;

  plcs_setup #(.PIXEL_BITS(PIXEL_BITS)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel_in),
    .r1        (in_knee_low),
    .s1        (out_knee_low),
    .r2        (in_knee_high),
    .s2        (out_knee_high),
    .out_valid (setup_valid),
    .out_ready (setup_ready),
    .mul_a0    (a0),
    .mul_b0    (b0),
    .mul_a1    (a1),
    .mul_b1    (b1),
    .width     (setup_width)
  );

  plcs_mul #(.PIXEL_BITS(PIXEL_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (setup_valid),
    .in_ready  (setup_ready),
    .a0        (a0),
    .b0        (b0),
    .a1        (a1),
    .b1        (b1),
    .width_in  (setup_width),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .num       (mul_num),
    .width     (mul_width)
  );

  // The quotient never exceeds MAXV, so it is already saturated.
  plcs_div #(.PIXEL_BITS(PIXEL_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .num       (mul_num),
    .width     (mul_width),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quotient  (pixel_out)
  );

  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Input back-pressure only arises from a stalled, full output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output side can move");

  // Right after reset the high knee registers hold their identity reset
  // value MAXV, never random register state.
  a_knees_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_knee_high == MAXV && out_knee_high == MAXV)
    else $error("knee registers not at their reset values");

endmodule

[tb/tb_piecewise_linear_contrast_stretch_unit.sv]
`timescale 1ns / 100ps

module tb_piecewise_linear_contrast_stretch_unit;
  import plcs_pkg::*;

  localparam int PIX_W = PIXEL_BITS_DEF;
  localparam int unsigned PIX_MAX = (1 << PIX_W) - 1;
  localparam int PIPE_DEPTH = PIX_W + 2;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 6;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int HOLD_OFF_AT = 560;
  localparam int SETTINGS_COUNT = 10;
  localparam int PIXELS_PER_SETTING = 65;

  // Mirrors the knee registers and keeps the stretched pixels still owed by the block.
  class stretch_scoreboard;
    int unsigned knee_r1 = 0;
    int unsigned knee_s1 = 0;
    int unsigned knee_r2 = PIX_MAX;
    int unsigned knee_s2 = PIX_MAX;
    logic [PIX_W-1:0] pending_pixels[$];
    int mismatches = 0;

    function void write_knee(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
      int unsigned v;
      v = value & PIX_MAX;
      case (idx)
        REG_IN_KNEE_LOW:   knee_r1 = v;
        REG_OUT_KNEE_LOW:  knee_s1 = v;
        REG_IN_KNEE_HIGH:  knee_r2 = v;
        REG_OUT_KNEE_HIGH: knee_s2 = v;
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] stretch_pixel(logic [PIX_W-1:0] pix);
      int unsigned x;
      int unsigned v;
      x = 32'(pix);
      if (x <= knee_r1) begin
        // A first segment of zero width yields its end level.
        if (knee_r1 == 0) v = knee_s1;
        else v = (knee_s1 * x) / knee_r1;
      end else if (x <= knee_r2) begin
        if (knee_r2 == knee_r1) v = knee_s2;
        else v = (knee_s1 * (knee_r2 - x) + knee_s2 * (x - knee_r1)) / (knee_r2 - knee_r1);
      end else begin
        if (knee_r2 == PIX_MAX) v = PIX_MAX;
        else v = (knee_s2 * (PIX_MAX - x) + PIX_MAX * (x - knee_r2)) / (PIX_MAX - knee_r2);
      end
      if (v > PIX_MAX) v = PIX_MAX;
      return v[PIX_W-1:0];
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      pending_pixels.push_back(stretch_pixel(pix));
    endfunction

    function void check_pixel(logic [PIX_W-1:0] actual);
      logic [PIX_W-1:0] wanted;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel_out, expected none, got %0d", $time, actual);
      end else begin
        wanted = pending_pixels.pop_front();
        if (actual !== wanted) begin
          mismatches++;
          $display("%0t: pixel_out mismatch, expected %0d, got %0d", $time, wanted, actual);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] pixel_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] pixel_out;

  stretch_scoreboard sb = new();
  int send_idle_pct = 14;
  int recv_idle_pct = 78;
  int results_seen = 0;
  bit hold_off_done = 1'b0;

  piecewise_linear_contrast_stretch_unit #(.PIXEL_BITS(PIX_W)) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_in(pixel_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_pixel(pixel_out);
      results_seen++;
    end
  end

  // Output side: random back-pressure, plus one long hold-off so the pipeline backs up.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_knee_reg(reg_idx_t idx, logic [PIX_W-1:0] level);
    logic [APB_DATA_BITS-1:0] data;
    // Upper bits carry junk now and then; the block must ignore them.
    data = ($urandom_range(3) == 0) ? APB_DATA_BITS'({$urandom(), level})
                                    : APB_DATA_BITS'(level);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_knee(idx, data);
  endtask

  task automatic set_knees(int r1, int s1, int r2, int s2);
    write_knee_reg(REG_IN_KNEE_LOW, PIX_W'(r1));
    write_knee_reg(REG_OUT_KNEE_LOW, PIX_W'(s1));
    write_knee_reg(REG_IN_KNEE_HIGH, PIX_W'(r2));
    write_knee_reg(REG_OUT_KNEE_HIGH, PIX_W'(s2));
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      pixel_in <= PIX_W'($urandom());
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(pix);
  endtask

  // Stops offering pixels until every pending result is out and the pipeline is empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_list(int pixels[]);
    foreach (pixels[i]) send_pixel(PIX_W'(pixels[i]));
    drain_pipeline();
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return PIX_W'(sb.knee_r1 - 1);
      1: return PIX_W'(sb.knee_r1);
      2: return PIX_W'(sb.knee_r1 + 1);
      3: return PIX_W'(sb.knee_r2 - 1);
      4: return PIX_W'(sb.knee_r2);
      5: return PIX_W'(sb.knee_r2 + 1);
      6: return PIX_W'($urandom_range(1) ? PIX_MAX : 0);
      default: return PIX_W'($urandom());
    endcase
  endfunction

  initial begin
    int r1;
    int s1;
    int r2;
    int s2;
    int wait_cycles;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset knees give the identity map.
    send_list('{0, 255, 85, 170});
    set_knees(64, 32, 192, 224);
    send_list('{0, 1, 63, 64, 65, 128, 191, 192, 193, 254, 255});
    // First knee at zero, second knee low.
    set_knees(0, 200, 100, 50);
    send_list('{0, 1, 100, 101, 255});
    // Second knee below the first: the middle segment is skipped.
    set_knees(200, 10, 50, 250);
    send_list('{50, 199, 200, 201, 255});

    for (int k = 0; k < SETTINGS_COUNT; k++) begin
      if (k == 4) begin
        send_idle_pct = 78;
        recv_idle_pct = 14;
      end else if (k == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r1 = $urandom_range(255);
      s1 = $urandom_range(255);
      r2 = $urandom_range(255);
      s2 = $urandom_range(255);
      case (k)
        0: begin r1 = 0; s1 = 0; r2 = 0; s2 = 0; end
        1: begin r1 = 255; s1 = 255; r2 = 255; s2 = 255; end
        2: begin r1 = 255; s1 = 0; r2 = 255; s2 = 0; end
        3: r2 = r1;
        4: begin r1 = 0; s1 = 255; r2 = 255; s2 = 0; end
        5: begin
          s1 = 255;
          s2 = 0;
          if (r1 > r2) begin r1 = r2; r2 = $urandom_range(255, r1); end
        end
        6: if (r2 > r1) begin r2 = r1; r1 = $urandom_range(255, r2); end
        default: ;
      endcase
      set_knees(r1, s1, r2, s2);
      for (int n = 0; n < PIXELS_PER_SETTING; n++) begin
        // One pause mid-stream with no register change.
        if (k == SETTINGS_COUNT - 1 && n == PIXELS_PER_SETTING / 2) drain_pipeline();
        send_pixel(pick_pixel());
      end
      drain_pipeline();
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_pixels.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_pixels.size() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d results never arrived, expected 0 left, got %0d", $time,
               sb.pending_pixels.size(), sb.pending_pixels.size());
    end
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
